FILE: hw/rtl/mqsb_pkg.sv
package mqsb_pkg;

    localparam int DATA_W = 32;
    localparam int QN_W   = 4;
    localparam int STAT_W = 2;

    typedef logic [STAT_W-1:0] t_status;

    // request kinds
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam t_status STAT_DONE  = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

endpackage

FILE: hw/rtl/mqsb_link_store.sv
module mqsb_link_store import mqsb_pkg::*; #(
    parameter int NUM_SLOTS = 256,
    parameter int LW        = $clog2(NUM_SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [LW-1:0] i_rd_addr,
    output logic [LW-1:0] o_rd_link,
    input  logic          i_wr_en,
    input  logic [LW-1:0] i_wr_addr,
    input  logic [LW-1:0] i_wr_link
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [LW-1:0] mem_lnk [NUM_SLOTS];
    logic [LW-1:0] r_rd_data;
    logic [LW-1:0] r_rd_addr;
    // slots at or above r_fill were never written: their link is still index + 1
    logic [LW-1:0] r_fill;
    logic [LW-1:0] n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_wr_en && (i_wr_addr == r_fill)) begin
            n_fill = r_fill + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_lnk[i_wr_addr[AW-1:0]] <= i_wr_link;
        end
        if (i_rd_en) begin
            r_rd_data <= mem_lnk[i_rd_addr[AW-1:0]];
            r_rd_addr <= i_rd_addr;
        end
    end

    assign o_rd_link = (r_rd_addr >= r_fill) ? (r_rd_addr + LW'(1)) : r_rd_data;

endmodule

FILE: hw/rtl/multi_queue_shared_buffer_unit.sv
// Channel   Signals                                        Handshake
// -------   --------------------------------------------   ------------------------------
// request   i_req_type, i_queue_number, i_data_in          taken when start && !busy
// result    o_data_out, o_status                           o_valid strobe, one cycle
//
// A completed request to a valid queue keeps busy high through S_QRD and then S_ENQW or
// S_DEQW, a full or empty refusal through S_QRD alone; the result strobes on the cycle
// busy drops, and a new request can be taken in that cycle. The link store has a single
// write port: an enqueue writes any old tail's link in S_QRD and its own in S_ENQW.
// A bad queue number answers on the next cycle without going busy.
// Reset is synchronous: all queues empty, free list back to slot 0, no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module multi_queue_shared_buffer_unit import mqsb_pkg::*; #(
    parameter int NUM_SLOTS  = 256,
    parameter int NUM_QUEUES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_req_type,
    input  logic [QN_W-1:0]          i_queue_number,
    input  logic signed [DATA_W-1:0] i_data_in,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_data_out,
    output t_status                  o_status
);

    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LW-1:0] LNK_NULL = LW'(NUM_SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_QRD  = 2'd1;
    localparam logic [1:0] S_ENQW = 2'd2;
    localparam logic [1:0] S_DEQW = 2'd3;

    logic [1:0]               r_state, n_state;
    logic                     r_req;
    logic [QW-1:0]            r_q;
    logic signed [DATA_W-1:0] r_data;
    logic [LW-1:0]            r_slot, n_slot;
    logic [LW-1:0]            r_free_head, n_free_head;
    logic [NUM_QUEUES-1:0]    r_qv, n_qv;
    logic                     r_hv;
    logic [2*LW-1:0]          r_qrd;
    logic signed [DATA_W-1:0] r_pay_rd;
    logic                     r_valid, n_valid;
    logic signed [DATA_W-1:0] r_data_out, n_data_out;
    t_status                  r_status, n_status;

    // head/tail per queue and slot payloads
    logic [2*LW-1:0]          mem_q   [NUM_QUEUES];
    logic signed [DATA_W-1:0] mem_pay [NUM_SLOTS];

    logic [8:0]      w_qn9;
    logic            w_qn_ok;
    logic [QW-1:0]   w_q;
    logic            w_accept;
    logic            w_qm_re;
    logic            w_qm_we;
    logic [2*LW-1:0] w_qm_wdata;
    logic            w_pay_we;
    logic            w_pay_re;
    logic            w_lnk_re;
    logic [LW-1:0]   w_lnk_raddr;
    logic [LW-1:0]   w_lnk;
    logic            w_lnk_we;
    logic [LW-1:0]   w_lnk_waddr;
    logic [LW-1:0]   w_lnk_wdata;
    logic [LW-1:0]   w_head;
    logic [LW-1:0]   w_tail;
    logic            w_head_slot;
    logic            w_fh_slot;

    assign w_qn9    = 9'(i_queue_number);
    assign w_qn_ok  = (w_qn9 != 9'd0) && (w_qn9 <= 9'(NUM_QUEUES));
    assign w_q      = QW'(w_qn9 - 9'd1);
    assign w_accept = start && (r_state == S_IDLE);
    assign w_qm_re  = w_accept && w_qn_ok;

    assign w_head      = r_hv ? r_qrd[2*LW-1:LW] : LNK_NULL;
    assign w_tail      = r_qrd[LW-1:0];
    assign w_head_slot = (w_head < LNK_NULL);
    assign w_fh_slot   = (r_free_head < LNK_NULL);

    mqsb_link_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .LW        (LW)
    ) u_lnk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_lnk_re),
        .i_rd_addr (w_lnk_raddr),
        .o_rd_link (w_lnk),
        .i_wr_en   (w_lnk_we),
        .i_wr_addr (w_lnk_waddr),
        .i_wr_link (w_lnk_wdata)
    );

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_free_head = r_free_head;
        n_qv        = r_qv;
        n_valid     = 1'b0;
        n_data_out  = r_data_out;
        n_status    = r_status;
        w_qm_we     = 1'b0;
        w_qm_wdata  = r_qrd;
        w_pay_we    = 1'b0;
        w_pay_re    = 1'b0;
        w_lnk_re    = 1'b0;
        w_lnk_raddr = r_free_head;
        w_lnk_we    = 1'b0;
        w_lnk_waddr = r_slot;
        w_lnk_wdata = LNK_NULL;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!w_qn_ok) begin
                        n_valid    = 1'b1;
                        n_data_out = '0;
                        n_status   = (i_req_type == REQ_DEQ) ? STAT_EMPTY : STAT_FULL;
                    end else begin
                        n_state  = S_QRD;
                        // fetch the link of the free head ahead of an enqueue
                        w_lnk_re = (i_req_type == REQ_ENQ) && w_fh_slot;
                    end
                end
            end
            S_QRD: begin
                if (r_req == REQ_ENQ) begin
                    if (!w_fh_slot) begin
                        n_state    = S_IDLE;
                        n_valid    = 1'b1;
                        n_data_out = '0;
                        n_status   = STAT_FULL;
                    end else begin
                        n_state     = S_ENQW;
                        n_slot      = r_free_head;
                        n_free_head = w_lnk;
                        n_qv[r_q]   = 1'b1;
                        w_qm_we     = 1'b1;
                        if (!w_head_slot) begin
                            w_qm_wdata = {r_free_head, r_free_head};
                        end else begin
                            w_qm_wdata = {w_head, r_free_head};
                            // chain the old tail to the new slot
                            w_lnk_we    = (w_tail < LNK_NULL);
                            w_lnk_waddr = w_tail;
                            w_lnk_wdata = r_free_head;
                        end
                    end
                end else begin
                    if (!w_head_slot) begin
                        n_state    = S_IDLE;
                        n_valid    = 1'b1;
                        n_data_out = '0;
                        n_status   = STAT_EMPTY;
                    end else begin
                        n_state     = S_DEQW;
                        n_slot      = w_head;
                        w_lnk_re    = 1'b1;
                        w_lnk_raddr = w_head;
                        w_pay_re    = 1'b1;
                    end
                end
            end
            S_ENQW: begin
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_slot;
                w_lnk_wdata = LNK_NULL;
                w_pay_we    = 1'b1;
                n_state     = S_IDLE;
                n_valid     = 1'b1;
                n_data_out  = '0;
                n_status    = STAT_DONE;
            end
            S_DEQW: begin
                // unlink the head and push its slot onto the free list
                w_qm_we     = 1'b1;
                w_qm_wdata  = {w_lnk, w_tail};
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_slot;
                w_lnk_wdata = r_free_head;
                n_free_head = r_slot;
                n_state     = S_IDLE;
                n_valid     = 1'b1;
                n_data_out  = r_pay_rd;
                n_status    = STAT_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_qv        <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_qv        <= n_qv;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_data_out <= n_data_out;
        r_status   <= n_status;
        if (w_accept) begin
            r_req  <= i_req_type;
            r_q    <= w_q;
            r_data <= i_data_in;
        end
        if (w_qm_re) begin
            r_hv <= r_qv[w_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_qm_we) begin
            mem_q[r_q] <= w_qm_wdata;
        end
        if (w_qm_re) begin
            r_qrd <= mem_q[w_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            mem_pay[r_slot[AW-1:0]] <= r_data;
        end
        if (w_pay_re) begin
            r_pay_rd <= mem_pay[w_head[AW-1:0]];
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_data_out = r_data_out;
    assign o_status   = r_status;

endmodule

FILE: hw/rtl/mqsb_checker.sv
module mqsb_checker import mqsb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     o_valid,
    input  logic signed [DATA_W-1:0] o_data_out,
    input  t_status                  o_status
);

    // an accepted beat either occupies the block or answers at once
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted request neither went busy nor answered");

    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && busy && $past(busy) |=> !busy)
        else $error("busy held longer than two cycles");

    // leaving busy always delivers the result beat
    a_done_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // failed requests return zero data and a known status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_DONE) |->
            (o_data_out == '0) && ((o_status == STAT_FULL) || (o_status == STAT_EMPTY)))
        else $error("bad status or nonzero data on failure");

endmodule

bind multi_queue_shared_buffer_unit mqsb_checker u_mqsb_checker (.*);

FILE: dv/multi_queue_shared_buffer_unit_tb.sv
`timescale 1ns / 1ps

module multi_queue_shared_buffer_unit_tb import mqsb_pkg::*;;

    localparam int NUM_SLOTS    = 256;
    localparam int NUM_QUEUES   = 8;
    localparam int LINK_W       = 9;
    localparam int SLOT_W       = 8;
    localparam int QUEUE_W      = 3;
    localparam int RANDOM_ITEMS = 1877;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 12;

    class buffer_scoreboard;
        typedef struct packed {
            logic [DATA_W-1:0] word;
            t_status           status;
        } t_reply;

        logic [LINK_W-1:0] heads [NUM_QUEUES];
        logic [LINK_W-1:0] tails [NUM_QUEUES];
        logic [LINK_W-1:0] links [NUM_SLOTS];
        logic [DATA_W-1:0] words [NUM_SLOTS];
        logic [LINK_W-1:0] free_head;
        t_reply            awaited_replies[$];
        int                errors;
        int                n_done;
        int                n_full;
        int                n_empty;

        function new();
            for (int q = 0; q < NUM_QUEUES; q++) begin
                heads[q] = LINK_W'(NUM_SLOTS);
                tails[q] = LINK_W'(NUM_SLOTS);
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
                links[s] = LINK_W'(s + 1);
                words[s] = '0;
            end
            free_head = '0;
            errors    = 0;
            n_done    = 0;
            n_full    = 0;
            n_empty   = 0;
        endfunction

        // Work out the reply to one accepted request and update the shadow store.
        function void note_request(logic kind, logic [QN_W-1:0] qn, logic [DATA_W-1:0] word);
            t_reply             r;
            logic [QUEUE_W-1:0] q;
            logic [LINK_W-1:0]  s;
            r.word = '0;
            if (qn == 0 || qn > NUM_QUEUES) begin
                r.status = (kind == REQ_DEQ) ? STAT_EMPTY : STAT_FULL;
            end else begin
                q = QUEUE_W'(qn - QN_W'(1));
                if (kind == REQ_ENQ) begin
                    if (free_head >= NUM_SLOTS) begin
                        r.status = STAT_FULL;
                    end else begin
                        s         = free_head;
                        free_head = links[s[SLOT_W-1:0]];
                        // empty queue: head and stale tail both get overwritten
                        if (heads[q] >= NUM_SLOTS) begin
                            heads[q] = s;
                        end else if (tails[q] < NUM_SLOTS) begin
                            links[tails[q][SLOT_W-1:0]] = s;
                        end
                        links[s[SLOT_W-1:0]] = LINK_W'(NUM_SLOTS);
                        tails[q] = s;
                        words[s[SLOT_W-1:0]] = word;
                        r.status = STAT_DONE;
                    end
                end else begin
                    if (heads[q] >= NUM_SLOTS) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        s         = heads[q];
                        heads[q]  = links[s[SLOT_W-1:0]];
                        links[s[SLOT_W-1:0]] = free_head;
                        free_head = s;
                        r.word    = words[s[SLOT_W-1:0]];
                        r.status  = STAT_DONE;
                    end
                end
            end
            awaited_replies.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] word, t_status status);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                $error("unexpected result: data_out=%h status=%0d", word, status);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            case (want.status)
                STAT_DONE:  n_done++;
                STAT_FULL:  n_full++;
                default:    n_empty++;
            endcase
            if (word !== want.word) begin
                $error("data_out mismatch: expected %h, actual %h", want.word, word);
                errors++;
            end
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                errors++;
            end
        endfunction

        function int pending_count();
            return awaited_replies.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_req_type;
    logic [QN_W-1:0]          i_queue_number;
    logic signed [DATA_W-1:0] i_data_in;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_data_out;
    t_status                  o_status;

    buffer_scoreboard sb = new();
    int               cycle_count = 0;
    int               burst_left  = 0;
    int               accepted    = 0;

    multi_queue_shared_buffer_unit #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_QUEUES (NUM_QUEUES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_queue_number (i_queue_number),
        .i_data_in      (i_data_in),
        .o_valid        (o_valid),
        .o_data_out     (o_data_out),
        .o_status       (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Check results before noting this edge's beat; a reply never comes on its own edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_data_out, o_status);
            if (start && !busy) begin
                sb.note_request(i_req_type, i_queue_number, i_data_in);
                accepted <= accepted + 1;
            end
        end
    end

    task automatic hold_idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start     <= 1'b0;
            i_data_in <= $urandom;
        end
    endtask

    task automatic issue_request(input logic kind, input logic [QN_W-1:0] qn,
                                 input logic [DATA_W-1:0] word);
        @(negedge i_clk);
        start          <= 1'b1;
        i_req_type     <= kind;
        i_queue_number <= qn;
        i_data_in      <= word;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic paced_request(input logic kind, input logic [QN_W-1:0] qn,
                                 input logic [DATA_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            hold_idle(gap);
        end
        burst_left--;
        issue_request(kind, qn, word);
    endtask

    task automatic drain_replies();
        hold_idle(1);
        while (sb.pending_count() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int                seg;
        int                seg_len;
        int                enq_pct;
        int                top_q;
        int                sent;
        logic              kind;
        logic [QN_W-1:0]   qn;
        logic [DATA_W-1:0] word;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req_type     = REQ_ENQ;
        i_queue_number = '0;
        i_data_in      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // data extremes through one queue, then empty and drained cases
        paced_request(REQ_DEQ, 4'd1, $urandom);
        paced_request(REQ_ENQ, 4'd1, 32'h8000_0000);
        paced_request(REQ_ENQ, 4'd1, 32'h7fff_ffff);
        paced_request(REQ_ENQ, 4'd1, 32'h0000_0000);
        paced_request(REQ_ENQ, 4'd1, 32'hffff_ffff);
        repeat (5) paced_request(REQ_DEQ, 4'd1, $urandom);
        // emptied queue keeps a stale tail; next enqueue must restart it
        paced_request(REQ_ENQ, 4'd3, 32'h1234_5678);
        paced_request(REQ_DEQ, 4'd3, $urandom);
        paced_request(REQ_ENQ, 4'd3, 32'hcafe_0001);
        paced_request(REQ_ENQ, 4'd3, 32'hcafe_0002);
        paced_request(REQ_DEQ, 4'd3, $urandom);
        paced_request(REQ_DEQ, 4'd3, $urandom);
        paced_request(REQ_ENQ, 4'd8, 32'h5a5a_a5a5);
        paced_request(REQ_DEQ, 4'd8, $urandom);
        // queue numbers outside 1..8
        paced_request(REQ_ENQ, 4'd0, 32'hdead_beef);
        paced_request(REQ_DEQ, 4'd0, $urandom);
        paced_request(REQ_ENQ, 4'd9, 32'h0bad_f00d);
        paced_request(REQ_DEQ, 4'd15, $urandom);
        paced_request(REQ_ENQ, 4'd15, $urandom);
        drain_replies();

        // First segment fills the store past full, second issues only dequeues over all queues.
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg == 0) begin
                seg_len = 290;
                enq_pct = 100;
                top_q   = NUM_QUEUES;
            end else if (seg == 1) begin
                seg_len = 300;
                enq_pct = 0;
                top_q   = NUM_QUEUES;
            end else begin
                seg_len = $urandom_range(40, 200);
                case ($urandom_range(0, 4))
                    0:       enq_pct = 5;
                    1:       enq_pct = 30;
                    2:       enq_pct = 50;
                    3:       enq_pct = 70;
                    default: enq_pct = 97;
                endcase
                top_q = $urandom_range(1, NUM_QUEUES);
                if ($urandom_range(0, 3) == 0)
                    drain_replies();
            end
            for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
                kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                if ($urandom_range(0, 19) == 0)
                    qn = $urandom_range(0, 1) ? QN_W'(0) : QN_W'($urandom_range(9, 15));
                else
                    qn = QN_W'($urandom_range(1, top_q));
                case ($urandom_range(0, 9))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7fff_ffff;
                    2:       word = '0;
                    3:       word = '1;
                    default: word = $urandom;
                endcase
                paced_request(kind, qn, word);
                sent++;
            end
            seg++;
        end

        drain_replies();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Covered %0d requests: %0d completed, %0d refused as full, %0d as empty.",
                 accepted, sb.n_done, sb.n_full, sb.n_empty);
        $display("Store filled to capacity and drained; out-of-range queue numbers included.");
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
